@@ hdl/cedd_pkg.sv @@
// Shared types, constants and rule tables for the fuzzy 24-bin color linker.
// Used by every module of the block; depends on nothing.
package cedd_pkg;

  localparam int FracBitsDefault = 15;
  localparam int BinWidthDefault = 47;

  localparam int WeightW   = 16;
  localparam int NumColors = 10;
  localparam int NumBins   = 24;
  localparam int BinIdxW   = 5;
  localparam int TotalW    = 47;
  localparam int IncW      = 17;  // largest bin increment is 131070

  localparam int KneeLo    = 68;
  localparam int KneeHi    = 188;
  localparam int SlopeSpan = 120;
  localparam int SlopeIdxW = 7;

  localparam int NumRules  = 4;
  localparam int NumShades = 3;

  // Rule table: saturation class, brightness class (1 = high), shade out.
  localparam logic [0:NumRules-1]       RuleSat = 4'b1001;
  localparam logic [0:NumRules-1]       RuleBri = 4'b1010;
  localparam logic [0:NumRules-1][1:0]  RuleOut = '{2'd1, 2'd2, 2'd0, 2'd2};

  localparam logic [BinIdxW-1:0] LastBinIdx = BinIdxW'(NumBins - 1);

  // Defuzzification methods
  localparam logic [1:0] MethodWinner = 2'd0;
  localparam logic [1:0] MethodVote   = 2'd1;
  localparam logic [1:0] MethodSum    = 2'd2;

  // Configuration register indexes
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 2;
  localparam logic [CfgIdxW-1:0] CfgDefuzz = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeep   = 2'd1;

  typedef struct packed {
    logic [7:0]         saturation;
    logic [7:0]         brightness;
    logic [WeightW-1:0] color_weight_0;
    logic [WeightW-1:0] color_weight_1;
    logic [WeightW-1:0] color_weight_2;
    logic [WeightW-1:0] color_weight_3;
    logic [WeightW-1:0] color_weight_4;
    logic [WeightW-1:0] color_weight_5;
    logic [WeightW-1:0] color_weight_6;
    logic [WeightW-1:0] color_weight_7;
    logic [WeightW-1:0] color_weight_8;
    logic [WeightW-1:0] color_weight_9;
  } pixel_t;

  typedef struct packed {
    logic [BinIdxW-1:0] bin_index;
    logic [TotalW-1:0]  bin_total;
    logic               last_bin;
  } bin_t;

  typedef logic [NumColors-1:0][WeightW-1:0] weights_t;

  // Sequencer status toward the top level
  typedef struct packed {
    logic idle;
    logic shade_load;
  } seq_ctrl_t;

endpackage

@@ hdl/fuzzy_24_bin_color_linker_top.sv @@
// Top level of the fuzzy 24-bin color linker: configuration registers, input
// register, shade unit and histogram engine. Depends on cedd_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) takes one pixel item:
//   saturation, brightness and ten Q1.15 color weights.
//   Output channel (out_valid_o / out_ready_i / out_item_o) returns 24 items
//   per pixel, bins 0 to 23 in order, last_bin set on bin 23.
//   Configuration channel (cfg_valid_i / cfg_ready_o / cfg_index_i /
//   cfg_data_i) is always ready; index 0 selects the defuzz method, index 1
//   the keep-previous flag. Write it only while the block is idle.
// Timing:
//   After an item is accepted the shades load (StShade), then bin reads issue
//   (StRun). Bins follow one per cycle while out_ready_i is high, set by the
//   single read-modify-write port of the histogram memory.
//   A new item is accepted once all 24 bins of the previous one are issued.
// Reset:
//   Clears both configuration registers and the sequencer; the histogram reads
//   as all zero until each bin has been written once.
// Stalls:
//   While out_ready_i is low the output item holds and the engine stops
//   issuing bin reads; nothing is dropped.
module fuzzy_24_bin_color_linker_top #(
  parameter int FracBits = cedd_pkg::FracBitsDefault,
  parameter int BinWidth = cedd_pkg::BinWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cedd_pkg::pixel_t              in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cedd_pkg::bin_t                out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cedd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cedd_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [1:0]               method_q;
  logic                     keep_q;
  cedd_pkg::pixel_t         item_q;
  cedd_pkg::weights_t       weights;
  cedd_pkg::seq_ctrl_t      ctrl;
  logic [2:0][FracBits+1:0] shade;
  logic                     start;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ctrl.idle;
  assign start       = in_valid_i && in_ready_o;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= cedd_pkg::MethodWinner;
      keep_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cedd_pkg::CfgDefuzz: method_q <= cfg_data_i[1:0];
        cedd_pkg::CfgKeep:   keep_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Hold the pixel for the whole pass over the bins.
  always_ff @(posedge clk_i) begin
    if (start) begin
      item_q <= in_item_i;
    end
  end

  assign weights = {item_q.color_weight_9, item_q.color_weight_8, item_q.color_weight_7,
                    item_q.color_weight_6, item_q.color_weight_5, item_q.color_weight_4,
                    item_q.color_weight_3, item_q.color_weight_2, item_q.color_weight_1,
                    item_q.color_weight_0};

  cedd_shade #(
    .FracBits (FracBits)
  ) u_shade (
    .clk_i    (clk_i),
    .load_i   (ctrl.shade_load),
    .method_i (method_q),
    .sat_i    (item_q.saturation),
    .bri_i    (item_q.brightness),
    .shade_o  (shade)
  );

  cedd_bin_engine #(
    .FracBits (FracBits),
    .BinWidth (BinWidth)
  ) u_bin_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .keep_i      (keep_q),
    .weights_i   (weights),
    .shade_i     (shade),
    .ctrl_o      (ctrl),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ hdl/cedd_shade.sv @@
// Membership trapezoids, fuzzy rules and defuzzification into three shades.
// Depends on cedd_pkg.
module cedd_shade #(
  parameter int FracBits = cedd_pkg::FracBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           load_i,
  input  logic [1:0]                     method_i,
  input  logic [7:0]                     sat_i,
  input  logic [7:0]                     bri_i,
  output logic [2:0][FracBits+1:0]       shade_o
);

  localparam int MW = FracBits + 1;
  localparam int SW = FracBits + 2;
  localparam logic [MW-1:0] OneMw = {1'b1, {FracBits{1'b0}}};
  localparam logic [SW-1:0] OneSw = {2'b01, {FracBits{1'b0}}};

  logic [MW-1:0] slope_lut [cedd_pkg::SlopeSpan];

  for (genvar g = 0; g < cedd_pkg::SlopeSpan; g++) begin : g_lut
    localparam logic [63:0] SlopeVal = (64'(g) << FracBits) / cedd_pkg::SlopeSpan;
    assign slope_lut[g] = SlopeVal[MW-1:0];
  end

  logic [1:0][7:0]    xv;
  logic [1:0][7:0]    d_lo;
  logic [1:0][7:0]    d_hi;
  logic [1:0][MW-1:0] m_lo;
  logic [1:0][MW-1:0] m_hi;

  assign xv = {bri_i, sat_i};

  // Channel 0 is saturation, channel 1 brightness.
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      d_lo[c] = 8'(cedd_pkg::KneeHi) - xv[c];
      d_hi[c] = xv[c] - 8'(cedd_pkg::KneeLo);
      if (xv[c] <= 8'(cedd_pkg::KneeLo)) begin
        m_lo[c] = OneMw;
        m_hi[c] = '0;
      end else if (xv[c] < 8'(cedd_pkg::KneeHi)) begin
        m_lo[c] = slope_lut[d_lo[c][cedd_pkg::SlopeIdxW-1:0]];
        m_hi[c] = slope_lut[d_hi[c][cedd_pkg::SlopeIdxW-1:0]];
      end else begin
        m_lo[c] = '0;
        m_hi[c] = OneMw;
      end
    end
  end

  logic [cedd_pkg::NumRules-1:0][MW-1:0] ra;
  logic [cedd_pkg::NumRules-1:0][MW-1:0] rb;
  logic [cedd_pkg::NumRules-1:0][MW-1:0] rmin;
  logic [cedd_pkg::NumRules-1:0]         ract;
  logic [MW-1:0]                         best;
  logic [1:0]                            win;
  logic                                  win_vld;
  logic [2:0][SW-1:0]                    shade_d;
  logic [2:0][SW-1:0]                    shade_q;

  always_comb begin
    best    = '0;
    win     = '0;
    win_vld = 1'b0;
    shade_d = '0;
    for (int r = 0; r < cedd_pkg::NumRules; r++) begin
      ra[r]   = cedd_pkg::RuleSat[r] ? m_hi[0] : m_lo[0];
      rb[r]   = cedd_pkg::RuleBri[r] ? m_hi[1] : m_lo[1];
      ract[r] = (ra[r] != '0) && (rb[r] != '0);
      rmin[r] = (ra[r] < rb[r]) ? ra[r] : rb[r];
    end
    unique case (method_i)
      cedd_pkg::MethodWinner: begin
        // earliest rule keeps a tie
        for (int r = 0; r < cedd_pkg::NumRules; r++) begin
          if (ract[r] && (rmin[r] > best)) begin
            best    = rmin[r];
            win     = cedd_pkg::RuleOut[r];
            win_vld = 1'b1;
          end
        end
        if (win_vld) begin
          shade_d[win] = OneSw;
        end
      end
      cedd_pkg::MethodVote: begin
        for (int r = 0; r < cedd_pkg::NumRules; r++) begin
          if (ract[r]) begin
            shade_d[cedd_pkg::RuleOut[r]] = shade_d[cedd_pkg::RuleOut[r]] + OneSw;
          end
        end
      end
      cedd_pkg::MethodSum: begin
        for (int r = 0; r < cedd_pkg::NumRules; r++) begin
          if (ract[r]) begin
            shade_d[cedd_pkg::RuleOut[r]] = shade_d[cedd_pkg::RuleOut[r]] + SW'(rmin[r]);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      shade_q <= shade_d;
    end
  end

  assign shade_o = shade_q;

endmodule

@@ hdl/cedd_bin_engine.sv @@
// Histogram memory with one read-modify-write per bin and the output register.
// Depends on cedd_pkg; takes shades from cedd_shade and weights from the top.
module cedd_bin_engine #(
  parameter int FracBits = cedd_pkg::FracBitsDefault,
  parameter int BinWidth = cedd_pkg::BinWidthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      keep_i,
  input  cedd_pkg::weights_t        weights_i,
  input  logic [2:0][FracBits+1:0]  shade_i,
  output cedd_pkg::seq_ctrl_t       ctrl_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output cedd_pkg::bin_t            out_item_o
);

  localparam int SW = FracBits + 2;
  localparam int PW = cedd_pkg::WeightW + SW;
  localparam int IW = cedd_pkg::IncW;
  localparam int BIW = cedd_pkg::BinIdxW;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StShade = 2'd1;
  localparam logic [1:0] StRun   = 2'd2;

  logic [1:0]     state_q, state_d;
  logic [BIW-1:0] bin_cnt_q, bin_cnt_d;
  logic [2:0]     grp_q, grp_d;
  logic [1:0]     sub_q, sub_d;
  logic           s2_valid_q, s2_valid_d;
  logic [BIW-1:0] s2_idx_q;
  logic           primed_q;
  logic           out_valid_q;
  cedd_pkg::bin_t out_item_q;

  logic [BinWidth-1:0] bin_mem [cedd_pkg::NumBins];
  logic [BinWidth-1:0] rdata_q;
  logic [IW-1:0]       inc_q, inc_d;

  logic                issue;
  logic                s2_fire;
  logic [3:0]          widx;
  logic [cedd_pkg::WeightW-1:0] wsel;
  logic [PW-1:0]       prod;
  logic [BinWidth-1:0] base;
  logic [BinWidth:0]   sum;
  logic [BinWidth-1:0] sum_sat;
  logic [63:0]         sum_ext;

  assign s2_fire = s2_valid_q && (!out_valid_q || out_ready_i);
  assign issue   = (state_q == StRun) && (!s2_valid_q || s2_fire);

  // Increment for the bin being issued; registered alongside the read.
  always_comb begin
    widx = {1'b0, grp_q} + 4'd2;
    wsel = weights_i[widx];
    prod = PW'(wsel) * PW'(shade_i[sub_q]);
    if (grp_q == 3'd0) begin
      inc_d = IW'(weights_i[{2'b00, sub_q}]);
    end else begin
      inc_d = prod[FracBits +: IW];
    end
  end

  // Saturating add; entries not yet written since reset read as zero.
  always_comb begin
    base    = (keep_i && primed_q) ? rdata_q : '0;
    sum     = {1'b0, base} + (BinWidth + 1)'(inc_q);
    sum_sat = sum[BinWidth] ? '1 : sum[BinWidth-1:0];
    sum_ext = 64'(sum_sat);
  end

  always_comb begin
    state_d    = state_q;
    bin_cnt_d  = bin_cnt_q;
    grp_d      = grp_q;
    sub_d      = sub_q;
    s2_valid_d = issue ? 1'b1 : (s2_fire ? 1'b0 : s2_valid_q);
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StShade;
        end
      end
      StShade: begin
        state_d = StRun;
      end
      StRun: begin
        if (issue) begin
          if (bin_cnt_q == cedd_pkg::LastBinIdx) begin
            state_d   = StIdle;
            bin_cnt_d = '0;
            grp_d     = '0;
            sub_d     = '0;
          end else begin
            bin_cnt_d = bin_cnt_q + 1'b1;
            if (sub_q == 2'd2) begin
              sub_d = '0;
              grp_d = grp_q + 1'b1;
            end else begin
              sub_d = sub_q + 1'b1;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bin_cnt_q   <= '0;
      grp_q       <= '0;
      sub_q       <= '0;
      s2_valid_q  <= 1'b0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      bin_cnt_q  <= bin_cnt_d;
      grp_q      <= grp_d;
      sub_q      <= sub_d;
      s2_valid_q <= s2_valid_d;
      if (s2_fire) begin
        out_valid_q <= 1'b1;
        if (s2_idx_q == cedd_pkg::LastBinIdx) begin
          primed_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Bins of two items sit at least a full pass apart, so read and write never
  // hit the same entry in one cycle.
  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      bin_mem[s2_idx_q] <= sum_sat;
    end
    if (issue) begin
      rdata_q  <= bin_mem[bin_cnt_q];
      inc_q    <= inc_d;
      s2_idx_q <= bin_cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      out_item_q.bin_index <= s2_idx_q;
      out_item_q.bin_total <= sum_ext[cedd_pkg::TotalW-1:0];
      out_item_q.last_bin  <= (s2_idx_q == cedd_pkg::LastBinIdx);
    end
  end

  assign ctrl_o.idle       = (state_q == StIdle);
  assign ctrl_o.shade_load = (state_q == StShade);
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_item_q;

endmodule

@@ hdl/cedd_checker.sv @@
// Port-level checks for the fuzzy 24-bin color linker, bound to the top level.
// Depends on cedd_pkg.
module cedd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input cedd_pkg::bin_t out_item_o
);

  logic [cedd_pkg::BinIdxW-1:0] exp_idx_q;

  // Track which bin the next result item must carry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      exp_idx_q <= (out_item_o.bin_index == cedd_pkg::LastBinIdx) ? '0 : exp_idx_q + 1'b1;
    end
  end

  a_bin_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.bin_index == exp_idx_q)
    else $error("result bin out of order");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.last_bin == (out_item_o.bin_index == cedd_pkg::LastBinIdx))
    else $error("last_bin does not match bin 23");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after accepting an item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

endmodule

bind fuzzy_24_bin_color_linker_top cedd_checker u_cedd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
